@@ rtl/lru_page_replacement_top_assert.svh @@
// Assertion macros used by the LRU page replacement top level.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrupr_pkg.sv @@
// Shared constants and types for the LRU page replacement block.
package lrupr_pkg;

  // Default geometry
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed port widths
  localparam int CFG_W      = 5;
  localparam int PAGE_IN_W  = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int TOTAL_W    = 32;
  localparam int WIDE_W     = 32;

  // Reset value of the frames-in-use register
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Rank update kinds
  localparam logic RK_TOUCH = 1'b0;
  localparam logic RK_FILL  = 1'b1;

  // Rank file update command
  typedef struct packed {
    logic en;
    logic kind;
  } rank_cmd_t;

endpackage

@@ rtl/lrupr_page_ram.sv @@
// Frame page store: one write port, one registered read port.
module lrupr_page_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lrupr_rank_file.sv @@
// Frame valid bits and recency ranks with parallel aging update.
module lrupr_rank_file #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF,
  localparam int IDX_W = $clog2(FRAMES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrupr_pkg::rank_cmd_t cmd,
  input  logic [IDX_W-1:0]     cmd_slot,
  input  logic [IDX_W-1:0]     cmd_old_rank,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic                 rd_valid,
  output logic [IDX_W-1:0]     rd_rank
);

  import lrupr_pkg::*;

  logic [FRAMES-1:0] valid_r;
  logic [FRAMES-1:0] valid_nxt;
  logic [IDX_W-1:0]  rank_r   [FRAMES];
  logic [IDX_W-1:0]  rank_nxt [FRAMES];

  // Aging: a fill ages every valid frame, a touch ages only the more recent ones
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (cmd.en) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (cmd.kind == RK_FILL) begin
          if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end else if (valid_r[i] && (rank_r[i] < cmd_old_rank)) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
      rank_nxt[cmd_slot]  = '0;
      valid_nxt[cmd_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '{default: '0};
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // Scan read
  assign rd_valid = valid_r[rd_idx];
  assign rd_rank  = rank_r[rd_idx];

endmodule

@@ rtl/lru_page_replacement_top.sv @@
// LRU page replacement top level: sequencer, frame scan compare unit, totals.
// The scan covers frames_in_use frames (clamped to 1..FRAMES), one frame per cycle.
// A new transaction is accepted only once the previous result has been loaded into the
// output register; in_stall is high from acceptance until then.
// Reset (rst_n low, synchronous): all frames empty, ranks and totals zero,
// frames_in_use back to 16, no result pending.
module lru_page_replacement_top #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lrupr_pkg::PAGE_IN_W-1:0]  in_page_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0] out_frame_slot,
  output logic                             out_evicted_valid,
  output logic [lrupr_pkg::PAGE_IN_W-1:0]  out_evicted_page,
  output logic [lrupr_pkg::TOTAL_W-1:0]    out_hit_total,
  output logic [lrupr_pkg::TOTAL_W-1:0]    out_fault_total
);

  import lrupr_pkg::*;

  `include "lru_page_replacement_top_assert.svh"

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_POST   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     frames_in_use_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     act_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;

  logic                 found_r, empty_r;
  logic [IDX_W-1:0]     hit_slot_r, hit_rank_r;
  logic [IDX_W-1:0]     empty_slot_r;
  logic [IDX_W-1:0]     vict_slot_r, best_rank_r;
  logic [PAGE_BITS-1:0] vict_page_r;

  logic [TOTAL_W-1:0]   hit_cnt_r, fault_cnt_r;

  logic                 res_hit_r, res_ev_r;
  logic [IDX_W-1:0]     res_slot_r;
  logic [PAGE_BITS-1:0] res_evpage_r;

  logic                  out_valid_r, out_hit_r, out_evicted_valid_r;
  logic [SLOT_OUT_W-1:0] out_frame_slot_r;
  logic [PAGE_IN_W-1:0]  out_evicted_page_r;
  logic [TOTAL_W-1:0]    out_hit_total_r, out_fault_total_r;

  logic                 in_acc, iss_vld, out_load;
  logic [WIDE_W-1:0]    in_ext, cfg_ext, ev_ext, slot_ext;
  logic [PAGE_BITS-1:0] page_in;
  logic [CNT_W-1:0]     act_in;
  logic [PAGE_BITS-1:0] ram_rdata;
  logic                 rk_valid;
  logic [IDX_W-1:0]     rk_rank;
  rank_cmd_t            rk_cmd;
  logic [IDX_W-1:0]     upd_slot, upd_old_rank;
  logic                 ram_we;

  // Input handshake and operand shaping
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_ext   = WIDE_W'(in_page_number);
  assign page_in  = in_ext[PAGE_BITS-1:0];
  assign cfg_ext  = WIDE_W'(frames_in_use_r);

  // Active frame count, clamped to 1..FRAMES
  always_comb begin
    if (frames_in_use_r == '0) begin
      act_in = CNT_W'(1);
    end else if (cfg_ext > WIDE_W'(FRAMES)) begin
      act_in = CNT_W'(FRAMES);
    end else begin
      act_in = CNT_W'(frames_in_use_r);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  // Sequencer
  assign iss_vld  = (state_r == ST_SCAN) && (rd_cnt_r < act_r);
  assign out_load = (state_r == ST_POST) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (!iss_vld && !cmp_vld_r) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_POST;
      ST_POST:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= iss_vld;
    end
  end

  // Read issue: one frame address per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r   <= page_in;
      act_r    <= act_in;
      rd_cnt_r <= '0;
    end else if (iss_vld) begin
      rd_cnt_r <= rd_cnt_r + CNT_W'(1);
    end
    if (iss_vld) begin
      cmp_idx_r <= rd_cnt_r[IDX_W-1:0];
    end
  end

  // Compare unit: match, first empty frame and oldest frame, one frame per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      found_r <= 1'b0;
      empty_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (rk_valid && (ram_rdata == page_r) && !found_r) begin
        found_r    <= 1'b1;
        hit_slot_r <= cmp_idx_r;
        hit_rank_r <= rk_rank;
      end
      if (!rk_valid && !empty_r) begin
        empty_r      <= 1'b1;
        empty_slot_r <= cmp_idx_r;
      end
      // lowest frame wins a tie
      if ((cmp_idx_r == '0) || (rk_rank > best_rank_r)) begin
        best_rank_r <= rk_rank;
        vict_slot_r <= cmp_idx_r;
        vict_page_r <= ram_rdata;
      end
    end
  end

  // Update commands for the rank file and page store
  always_comb begin
    upd_slot     = found_r ? hit_slot_r : (empty_r ? empty_slot_r : vict_slot_r);
    upd_old_rank = found_r ? hit_rank_r : best_rank_r;
    rk_cmd.en    = (state_r == ST_UPDATE);
    rk_cmd.kind  = (!found_r && empty_r) ? RK_FILL : RK_TOUCH;
    ram_we       = (state_r == ST_UPDATE) && !found_r;
  end

  lrupr_page_ram #(
    .DEPTH (FRAMES),
    .WIDTH (PAGE_BITS)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_slot),
    .wdata (page_r),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  lrupr_rank_file #(
    .FRAMES (FRAMES)
  ) u_rank_file (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (rk_cmd),
    .cmd_slot     (upd_slot),
    .cmd_old_rank (upd_old_rank),
    .rd_idx       (cmp_idx_r),
    .rd_valid     (rk_valid),
    .rd_rank      (rk_rank)
  );

  // Saturating totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
    end else if (state_r == ST_UPDATE) begin
      if (found_r) begin
        if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + TOTAL_W'(1);
      end else begin
        if (fault_cnt_r != '1) fault_cnt_r <= fault_cnt_r + TOTAL_W'(1);
      end
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      res_hit_r    <= found_r;
      res_ev_r     <= !found_r && !empty_r;
      res_slot_r   <= upd_slot;
      res_evpage_r <= (!found_r && !empty_r) ? vict_page_r : '0;
    end
  end

  assign ev_ext   = WIDE_W'(res_evpage_r);
  assign slot_ext = WIDE_W'(res_slot_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r           <= res_hit_r;
      out_frame_slot_r    <= slot_ext[SLOT_OUT_W-1:0];
      out_evicted_valid_r <= res_ev_r;
      out_evicted_page_r  <= ev_ext[PAGE_IN_W-1:0];
      out_hit_total_r     <= hit_cnt_r;
      out_fault_total_r   <= fault_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_frame_slot_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_hit_total     = out_hit_total_r;
  assign out_fault_total   = out_fault_total_r;

  // Checks
  `LRUPR_ASSERT_NEXT(a_acc_scan, clk, rst_n, in_acc, state_r == ST_SCAN, "accepted item did not start a scan")
  `LRUPR_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid_r, !(out_hit_r && out_evicted_valid_r), "hit reported an eviction")
  `LRUPR_ASSERT_NOW(a_evpage_zero, clk, rst_n, out_valid_r && !out_evicted_valid_r, out_evicted_page_r == '0, "evicted page nonzero without eviction")
  `LRUPR_ASSERT_NEXT(a_update_post, clk, rst_n, state_r == ST_UPDATE, (state_r == ST_POST) && (rd_cnt_r == act_r), "update not followed by result stage")

endmodule
